@@ hw/rtl/wuf_pkg.sv @@
// Shared types and constants for the weighted union-find block.
package wuf_pkg;

  localparam int NODE_W = 10;
  localparam int POT_W = 32;
  localparam int CNT_W = 11;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;
  localparam logic REG_NODE_COUNT = 1'b0;

  localparam logic FUNC_RELATE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic func;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic signed [POT_W-1:0] difference;
  } in_word_t;

  typedef struct packed {
    logic consistent;
    logic joined;
    logic bad_index;
    logic [NODE_W-1:0] root_label;
    logic signed [POT_W-1:0] node_potential;
  } out_word_t;

  typedef enum logic [1:0] {
    RES_BAD = 2'd0,
    RES_QUERY = 2'd1,
    RES_CHECK = 2'd2,
    RES_JOIN = 2'd3
  } res_kind_t;

  typedef struct packed {
    logic idle;
    logic latch_in;
    logic init_step;
    logic wr_keep;
    logic wr_move;
    logic scan_step;
    logic out_load;
    res_kind_t kind;
  } wuf_cmd_t;

  typedef struct packed {
    logic bad;
    logic func;
    logic same;
    logic cnt_last;
    logic out_free;
  } wuf_stat_t;

endpackage

@@ hw/rtl/wuf_ctrl.sv @@
// Controller state machine that sequences clearing, lookups, merges and result delivery.
module wuf_ctrl
  import wuf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  wuf_stat_t stat,
  output wuf_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_NODES = 9'b000001000,
    S_SIZES = 9'b000010000,
    S_ZERO  = 9'b000100000,
    S_SCAN  = 9'b001000000,
    S_DRAIN = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  res_kind_t kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      kind_r <= RES_BAD;
    end else begin
      state_r <= state_nxt;
      kind_r <= kind_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt = kind_r;
    cmd = '0;
    cmd.kind = kind_r;
    case (state_r)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (stat.cnt_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.bad) begin
          kind_nxt = RES_BAD;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_NODES;
        end
      end
      S_NODES: begin
        if (stat.func == FUNC_QUERY) begin
          kind_nxt = RES_QUERY;
          state_nxt = S_DONE;
        end else if (stat.same) begin
          kind_nxt = RES_CHECK;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SIZES;
        end
      end
      S_SIZES: begin
        cmd.wr_keep = 1'b1;
        state_nxt = S_ZERO;
      end
      S_ZERO: begin
        cmd.wr_move = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.cnt_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        kind_nxt = RES_JOIN;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

@@ hw/rtl/wuf_dp.sv @@
// Datapath with the label, potential and size tables, the scan counter and the result register.
module wuf_dp
  import wuf_pkg::*;
#(
  parameter int MAX_NODES = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wuf_cmd_t         cmd,
  input  in_word_t         in_word,
  input  logic [CNT_W-1:0] node_count,
  input  logic             out_stall,
  output wuf_stat_t        stat,
  output logic             out_valid,
  output out_word_t        out_word
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int SZ_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);

  logic [IDX_W-1:0] lab_mem [MAX_NODES];
  logic [POT_W-1:0] pot_mem [MAX_NODES];
  logic [SZ_W-1:0]  size_mem [MAX_NODES];

  in_word_t in_r;
  logic bad_r;
  logic [IDX_W-1:0] cnt_r;
  logic scan_vld_r;
  logic [IDX_W-1:0] scan_wa_r;
  logic [IDX_W-1:0] lk_r, lm_r;
  logic [POT_W-1:0] shift_r, pa_r;
  logic move_a_r;
  logic out_valid_r;
  out_word_t out_word_r, out_word_nxt;

  logic [IDX_W-1:0] lab_rd_a_r, lab_rd_b_r;
  logic [POT_W-1:0] pot_rd_a_r, pot_rd_b_r;
  logic [SZ_W-1:0]  size_rd_a_r, size_rd_b_r;

  logic ok_a, ok_b;
  logic [IDX_W-1:0] a_idx, b_idx, ra;
  logic move_a;
  logic [IDX_W-1:0] lk, lm;
  logic [POT_W-1:0] dd, pk, pm, shift;
  logic scan_hit;
  logic tab_we;
  logic [IDX_W-1:0] tab_wa, lab_wd;
  logic [POT_W-1:0] pot_wd;
  logic size_we;
  logic [IDX_W-1:0] size_wa;
  logic [SZ_W-1:0] size_wd;

  assign ok_a = (CNT_W'(in_word.node_a) < node_count) &&
                (32'(in_word.node_a) < 32'(MAX_NODES));
  assign ok_b = (CNT_W'(in_word.node_b) < node_count) &&
                (32'(in_word.node_b) < 32'(MAX_NODES));

  assign a_idx = IDX_W'(in_r.node_a);
  assign b_idx = IDX_W'(in_r.node_b);
  assign ra = cmd.scan_step ? cnt_r : a_idx;

  assign move_a = size_rd_a_r < size_rd_b_r;
  assign lk = move_a ? lab_rd_b_r : lab_rd_a_r;
  assign lm = move_a ? lab_rd_a_r : lab_rd_b_r;
  assign dd = move_a ? (POT_W'(0) - POT_W'(in_r.difference)) : POT_W'(in_r.difference);
  assign pk = move_a ? pot_rd_b_r : pot_rd_a_r;
  assign pm = move_a ? pot_rd_a_r : pot_rd_b_r;
  assign shift = pk + dd - pm;

  assign scan_hit = scan_vld_r && (lab_rd_a_r == lm_r);
  assign tab_we = cmd.init_step || scan_hit;
  assign tab_wa = cmd.init_step ? cnt_r : scan_wa_r;
  assign lab_wd = cmd.init_step ? cnt_r : lk_r;
  assign pot_wd = cmd.init_step ? '0 : (pot_rd_a_r + shift_r);

  assign size_we = cmd.init_step || cmd.wr_keep || cmd.wr_move;
  assign size_wa = cmd.init_step ? cnt_r : (cmd.wr_keep ? lk : lm_r);
  assign size_wd = cmd.init_step ? SZ_W'(1) :
                   (cmd.wr_keep ? SZ_W'(size_rd_a_r + size_rd_b_r) : '0);

  always_ff @(posedge clk) begin
    if (tab_we) begin
      lab_mem[tab_wa] <= lab_wd;
    end
    lab_rd_a_r <= lab_mem[ra];
    lab_rd_b_r <= lab_mem[b_idx];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      pot_mem[tab_wa] <= pot_wd;
    end
    pot_rd_a_r <= pot_mem[ra];
    pot_rd_b_r <= pot_mem[b_idx];
  end

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_wa] <= size_wd;
    end
    size_rd_a_r <= size_mem[lab_rd_a_r];
    size_rd_b_r <= size_mem[lab_rd_b_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      scan_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.init_step || cmd.scan_step) begin
        cnt_r <= (cnt_r == LAST_IDX) ? '0 : cnt_r + IDX_W'(1);
      end else if (cmd.wr_move) begin
        cnt_r <= '0;
      end
      scan_vld_r <= cmd.scan_step;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_wa_r <= cnt_r;
    if (cmd.latch_in) begin
      in_r <= in_word;
      bad_r <= !(ok_a && ((in_word.func == FUNC_QUERY) || ok_b));
    end
    if (cmd.wr_keep) begin
      lk_r <= lk;
      lm_r <= lm;
      shift_r <= shift;
      move_a_r <= move_a;
      pa_r <= pot_rd_a_r;
    end
    if (cmd.out_load) begin
      out_word_r <= out_word_nxt;
    end
  end

  always_comb begin
    out_word_nxt = '0;
    case (cmd.kind)
      RES_BAD: begin
        out_word_nxt.bad_index = 1'b1;
      end
      RES_QUERY: begin
        out_word_nxt.root_label = NODE_W'(lab_rd_a_r);
        out_word_nxt.node_potential = pot_rd_a_r;
      end
      RES_CHECK: begin
        out_word_nxt.consistent =
          (POT_W'(pot_rd_b_r - pot_rd_a_r) == POT_W'(in_r.difference));
        out_word_nxt.root_label = NODE_W'(lab_rd_a_r);
        out_word_nxt.node_potential = pot_rd_a_r;
      end
      RES_JOIN: begin
        out_word_nxt.consistent = 1'b1;
        out_word_nxt.joined = 1'b1;
        out_word_nxt.root_label = NODE_W'(lk_r);
        out_word_nxt.node_potential = move_a_r ? (pa_r + shift_r) : pa_r;
      end
      default: begin
        out_word_nxt = '0;
      end
    endcase
  end

  assign stat.bad = bad_r;
  assign stat.func = in_r.func;
  assign stat.same = (lab_rd_a_r == lab_rd_b_r);
  assign stat.cnt_last = (cnt_r == LAST_IDX);
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_word = out_word_r;

endmodule

@@ hw/rtl/weighted_union_find.sv @@
// Top level of the weighted union-find block with its configuration register.
//
//   channel   direction  word          handshake
//   in_       input      in_word_t     in_valid / in_stall
//   out_      output     out_word_t    out_valid / out_stall
//   cfg_      input      node_count    APB write / read, pready always high
//
// A query or a check within one component passes S_NODES; a rejected index skips it.
// A merge scans the whole label table, one entry a cycle, between S_ZERO and S_DRAIN.
// After reset the tables are cleared while in_stall is high.
// A new word is taken while a finished result still waits on out_stall.
module weighted_union_find
  import wuf_pkg::*;
#(
  parameter int MAX_NODES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_word,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  wuf_cmd_t cmd;
  wuf_stat_t stat;
  logic [CNT_W-1:0] node_count_r;
  logic cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit = (cfg_paddr[CFG_AW-1:2] == REG_NODE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      node_count_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  assign cfg_prdata = cfg_hit ? CFG_DW'(node_count_r) : '0;

  assign in_stall = !cmd.idle;

  wuf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  wuf_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_word    (in_word),
    .node_count (node_count_r),
    .out_stall  (out_stall),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_word   (out_word)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while one is in flight");

  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.bad_index |-> !out_word.joined && !out_word.consistent &&
      (out_word.root_label == '0) && (out_word.node_potential == '0))
    else $error("rejected word carries data");

  a_join_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.joined |-> out_word.consistent && !out_word.bad_index)
    else $error("merge reported without consistency");

endmodule

@@ verif/wuf_checker.sv @@
// Checker for the weighted union-find block: mirrors its tables and compares every result word.
module wuf_checker
  import wuf_pkg::*;
#(
  parameter int MAX_NODES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_word_t          in_word,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_word_t         out_word,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output int                fail_count,
  output int                answers_waiting
);

  localparam logic [CFG_AW-1:0] NODE_COUNT_ADDR = CFG_AW'(4 * REG_NODE_COUNT);

  logic [NODE_W-1:0] label_of [MAX_NODES];
  logic [POT_W-1:0]  pot_of [MAX_NODES];
  logic [CNT_W-1:0]  size_of [MAX_NODES];
  logic [CNT_W-1:0]  node_limit;
  out_word_t         answers_due [$];

  function automatic bit node_in_use(input logic [NODE_W-1:0] idx);
    return int'(idx) < int'(node_limit) && int'(idx) < MAX_NODES;
  endfunction

  function automatic out_word_t union_find_step(input in_word_t w);
    out_word_t r;
    logic [NODE_W-1:0] la, lb, keep_lbl, move_lbl, keep_n, move_n;
    logic [POT_W-1:0] d, shift;
    r = '0;
    if (!node_in_use(w.node_a) || (w.func == FUNC_RELATE && !node_in_use(w.node_b))) begin
      r.bad_index = 1'b1;
      return r;
    end
    if (w.func == FUNC_RELATE) begin
      la = label_of[w.node_a];
      lb = label_of[w.node_b];
      d = w.difference;
      if (la == lb) begin
        r.consistent = (pot_of[w.node_b] - pot_of[w.node_a]) == d;
      end else begin
        keep_n = w.node_a;
        move_n = w.node_b;
        keep_lbl = la;
        move_lbl = lb;
        if (size_of[la] < size_of[lb]) begin
          keep_n = w.node_b;
          move_n = w.node_a;
          keep_lbl = lb;
          move_lbl = la;
          d = '0 - d;
        end
        shift = pot_of[keep_n] + d - pot_of[move_n];
        size_of[keep_lbl] = size_of[keep_lbl] + size_of[move_lbl];
        size_of[move_lbl] = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
          if (label_of[i] == move_lbl) begin
            label_of[i] = keep_lbl;
            pot_of[i] = pot_of[i] + shift;
          end
        end
        r.consistent = 1'b1;
        r.joined = 1'b1;
      end
    end
    r.root_label = label_of[w.node_a];
    r.node_potential = pot_of[w.node_a];
    return r;
  endfunction

  task automatic report_failure(input string what, input out_word_t want, input out_word_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s: expected consistent=%0b joined=%0b bad_index=%0b root_label=%0d potential=%0d, got consistent=%0b joined=%0b bad_index=%0b root_label=%0d potential=%0d",
               what, want.consistent, want.joined, want.bad_index, want.root_label,
               want.node_potential, got.consistent, got.joined, got.bad_index,
               got.root_label, got.node_potential);
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        label_of[i] = NODE_W'(i);
        pot_of[i] = '0;
        size_of[i] = CNT_W'(1);
      end
      node_limit = NODE_COUNT_RST;
      answers_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == NODE_COUNT_ADDR) begin
        node_limit = cfg_pwdata[CNT_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          report_failure("unexpected result word", '0, out_word);
        end else begin
          want = answers_due.pop_front();
          if (out_word.consistent !== want.consistent || out_word.joined !== want.joined ||
              out_word.bad_index !== want.bad_index || out_word.root_label !== want.root_label ||
              out_word.node_potential !== want.node_potential) begin
            report_failure("result word mismatch", want, out_word);
          end
        end
      end
      if (in_valid && !in_stall) begin
        answers_due.push_back(union_find_step(in_word));
      end
    end
    answers_waiting = answers_due.size();
  end

endmodule

@@ verif/weighted_union_find_test.sv @@
// Testbench top for the weighted union-find block: stimulus, configuration and verdict.
module weighted_union_find_test
  import wuf_pkg::*;
();

  localparam int MAX_NODES = 1024;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [CFG_AW-1:0] NODE_COUNT_ADDR = CFG_AW'(4 * REG_NODE_COUNT);

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_word_t          in_word;
  logic              out_valid;
  logic              out_stall;
  out_word_t         out_word;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int                fail_count;
  int                answers_waiting;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  logic              hold_req;
  int                quiet_cycles = 0;
  logic [POT_W-1:0]  plan_pot [MAX_NODES];

  always #6 clk = ~clk;

  weighted_union_find #(.MAX_NODES(MAX_NODES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  wuf_checker #(.MAX_NODES(MAX_NODES)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .fail_count(fail_count), .answers_waiting(answers_waiting)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("weighted_union_find_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The receiver holds off once for a long stretch when asked, else stalls at random.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        for (int held = 0; held < HOLD_CYCLES; held++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic in_word_t make_word(input logic func, input int a, input int b,
                                         input logic [POT_W-1:0] diff);
    in_word_t w;
    w.func = func;
    w.node_a = NODE_W'(a);
    w.node_b = NODE_W'(b);
    w.difference = diff;
    return w;
  endfunction

  function automatic logic [NODE_W-1:0] pick_node(input int span);
    if ($urandom_range(99) < 85) return NODE_W'($urandom_range(span - 1));
    return NODE_W'($urandom);
  endfunction

  function automatic in_word_t random_word(input int span);
    in_word_t w;
    int roll;
    w.func = ($urandom_range(99) < 25) ? FUNC_QUERY : FUNC_RELATE;
    w.node_a = pick_node(span);
    w.node_b = ($urandom_range(99) < 5) ? w.node_a : pick_node(span);
    roll = $urandom_range(99);
    if (roll < 70) begin
      w.difference = plan_pot[w.node_b] - plan_pot[w.node_a];
    end else if (roll < 80) begin
      w.difference = plan_pot[w.node_b] - plan_pot[w.node_a] + 1;
    end else begin
      w.difference = $urandom;
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_waiting != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic run_phase(input int count, input int send_pct, input int recv_pct,
                           input int items, input bit pressure);
    int span;
    drain();
    write_reg(NODE_COUNT_ADDR, CFG_DW'(count));
    span = (count == 0 || count > MAX_NODES) ? MAX_NODES : count;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int k = 0; k < items; k++) begin
      if (pressure && k == 5) hold_req <= 1'b1;
      if (pressure && k == items / 2) drain();
      send_word(random_word(span));
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    hold_req <= 1'b0;
    for (int i = 0; i < MAX_NODES; i++) plan_pot[i] = $urandom;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Full table after reset: merges, checks, ties, wrap-around and a node related to itself.
    send_word(make_word(FUNC_QUERY, 0, 0, 0));
    send_word(make_word(FUNC_QUERY, 1023, 1023, 32'hffff_ffff));
    send_word(make_word(FUNC_RELATE, 0, 1, 5));
    send_word(make_word(FUNC_RELATE, 1, 0, -5));
    send_word(make_word(FUNC_RELATE, 0, 1, 6));
    send_word(make_word(FUNC_RELATE, 2, 2, 0));
    send_word(make_word(FUNC_RELATE, 2, 2, 32'h7fff_ffff));
    send_word(make_word(FUNC_RELATE, 1023, 1022, 32'h8000_0000));
    send_word(make_word(FUNC_RELATE, 1022, 1023, 32'h8000_0000));
    send_word(make_word(FUNC_RELATE, 2, 0, 32'h7fff_ffff));
    send_word(make_word(FUNC_QUERY, 2, 0, 0));
    send_word(make_word(FUNC_RELATE, 1023, 3, -1));
    send_word(make_word(FUNC_QUERY, 3, 0, 0));
    send_word(make_word(FUNC_QUERY, 1022, 0, 0));
    send_word(make_word(FUNC_RELATE, 1022, 1, 12345));
    send_word(make_word(FUNC_QUERY, 0, 0, 0));
    send_word(make_word(FUNC_QUERY, 1023, 0, 0));

    // Small table: rejected indices on either side of a relation and on a query.
    drain();
    write_reg(NODE_COUNT_ADDR, CFG_DW'(4));
    send_word(make_word(FUNC_RELATE, 0, 5, 0));
    send_word(make_word(FUNC_RELATE, 7, 0, 0));
    send_word(make_word(FUNC_QUERY, 5, 0, 0));
    send_word(make_word(FUNC_QUERY, 1, 1023, 0));
    send_word(make_word(FUNC_RELATE, 1023, 1023, 0));
    send_word(make_word(FUNC_RELATE, 3, 3, 0));

    run_phase(16, 0, 0, 80, 1'b0);
    run_phase(64, 70, 0, 80, 1'b0);
    run_phase(1, 0, 70, 40, 1'b0);
    run_phase(2047, 20, 20, 50, 1'b0);
    run_phase(0, 20, 20, 30, 1'b0);
    run_phase(256, 0, 0, 90, 1'b0);
    run_phase(1024, 0, 70, 60, 1'b0);
    run_phase(40, 20, 20, 90, 1'b1);
    run_phase(700, 0, 0, 40, 1'b0);

    drain();
    repeat (MAX_NODES + 64) @(posedge clk);
    if (fail_count == 0 && answers_waiting == 0) begin
      $display("weighted_union_find_test: done, clean");
    end else begin
      $display("weighted_union_find_test: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/wuf_pkg.sv
hw/rtl/wuf_ctrl.sv
hw/rtl/wuf_dp.sv
hw/rtl/weighted_union_find.sv
verif/wuf_checker.sv
verif/weighted_union_find_test.sv
